### src/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants and types for the closest-point-on-triangle pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int COORD_BITS = 32;

	// region codes
	localparam logic [2:0] RGN_A     = 3'd0;
	localparam logic [2:0] RGN_B     = 3'd1;
	localparam logic [2:0] RGN_AB    = 3'd2;
	localparam logic [2:0] RGN_C     = 3'd3;
	localparam logic [2:0] RGN_AC    = 3'd4;
	localparam logic [2:0] RGN_BC    = 3'd5;
	localparam logic [2:0] RGN_INNER = 3'd6;
	localparam logic [2:0] RGN_DEGEN = 3'd7;

	typedef struct packed {
		logic neg;
		logic ovf;
	} div_flags_t;

endpackage

### src/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined restoring divider, one quotient bit per stage, with side tag.
// ----------------------------------------------------------------------------
module cpt_div #(
	parameter int NW = 172,
	parameter int DW = 139,
	parameter int QW = 33,
	parameter int TW = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NW-1:0]        num,
	input  logic [DW-1:0]        den,
	input  cpt_pkg::div_flags_t  flg,
	input  logic [TW-1:0]        tag,
	output logic [QW-1:0]        quo,
	output cpt_pkg::div_flags_t  flg_o,
	output logic [TW-1:0]        tag_o
);

	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [RW-1:0]       rem_s [QW];
	logic [DW-1:0]       den_s [QW];
	logic [QW-1:0]       quo_s [QW];
	cpt_pkg::div_flags_t flg_s [QW];
	logic [TW-1:0]       tag_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [RW-1:0]       rin;
		logic [RW-1:0]       trial;
		logic [DW-1:0]       din;
		logic [QW-1:0]       qin;
		cpt_pkg::div_flags_t fin;
		logic [TW-1:0]       tin;

		if (g == 0) begin : g_first
			assign rin = RW'(num);
			assign din = den;
			assign qin = '0;
			assign fin = flg;
			assign tin = tag;
		end else begin : g_next
			assign rin = rem_s[g-1];
			assign din = den_s[g-1];
			assign qin = quo_s[g-1];
			assign fin = flg_s[g-1];
			assign tin = tag_s[g-1];
		end

		assign trial = RW'(din) << (QW - 1 - g);

		always_ff @(posedge clk) begin
			if (en) begin
				if (rin >= trial) begin
					rem_s[g] <= rin - trial;
					quo_s[g] <= {qin[QW-2:0], 1'b1};
				end else begin
					rem_s[g] <= rin;
					quo_s[g] <= {qin[QW-2:0], 1'b0};
				end
				den_s[g] <= din;
				flg_s[g] <= fin;
				tag_s[g] <= tin;
			end
		end
	end

	assign quo   = quo_s[QW-1];
	assign flg_o = flg_s[QW-1];
	assign tag_o = tag_s[QW-1];

endmodule

### src/closest_point_on_triangle.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle
// Nearest point of a 3-D triangle to a query point, Voronoi-region method.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_ready) carries the query point and the
//   three vertices as signed fixed-point coordinates. Output channel
//   (result_valid/result_ready) carries the nearest point and its region
//   code (vertex, edge, interior or degenerate).
//   From accepted input to valid result a transaction passes through
//   14 arithmetic stages for the dot products,
//   barycentric terms and numerators, COORD_BITS+1 divider stages (one
//   quotient bit each) and the output register.
//   Throughput is one transaction per cycle while the output is not stalled. The whole pipeline advances
//   together; while a result waits at the output with result_ready low,
//   every stage holds and item_ready is low, so nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline is empty and ready at once.
// ----------------------------------------------------------------------------
module closest_point_on_triangle #(
	parameter int COORD_BITS = cpt_pkg::COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	input  logic signed [COORD_BITS-1:0] vert_a_x,
	input  logic signed [COORD_BITS-1:0] vert_a_y,
	input  logic signed [COORD_BITS-1:0] vert_a_z,
	input  logic signed [COORD_BITS-1:0] vert_b_x,
	input  logic signed [COORD_BITS-1:0] vert_b_y,
	input  logic signed [COORD_BITS-1:0] vert_b_z,
	input  logic signed [COORD_BITS-1:0] vert_c_x,
	input  logic signed [COORD_BITS-1:0] vert_c_y,
	input  logic signed [COORD_BITS-1:0] vert_c_z,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic signed [COORD_BITS-1:0] near_x,
	output logic signed [COORD_BITS-1:0] near_y,
	output logic signed [COORD_BITS-1:0] near_z,
	output logic [2:0]                   region
);

	localparam int C    = COORD_BITS;
	localparam int V    = C + 1;              // edge/offset vectors
	localparam int PW   = 2 * V;              // one coordinate product
	localparam int DOT  = 2 * V + 2;          // dot products
	localparam int H1   = DOT / 2;            // split point of dot products
	localparam int XW   = H1 + 1;             // split halves, signed
	localparam int PPW  = 2 * XW;             // partial products
	localparam int BW   = 2 * DOT;            // full product of two dots
	localparam int BAR  = 2 * DOT + 1;        // vc, vb, va
	localparam int DEN  = BAR + 2;            // va+vb+vc
	localparam int EW   = DOT + 2;            // edge divisors
	localparam int P    = (BAR + 3) / 4;      // piece width of weights
	localparam int QPW  = V + P + 1;          // vector times piece
	localparam int UW   = V + BAR;            // vector times weight
	localparam int NUM  = UW + 1;             // numerator
	localparam int NMW  = NUM + 1;            // numerator plus half divisor
	localparam int QW   = C + 1;              // quotient bits kept
	localparam int RW   = (NMW > DEN + QW) ? NMW : DEN + QW;
	localparam int NS   = 14;
	localparam int NV   = NS + QW;
	localparam int LIX [6] = '{0, 2, 4, 0, 2, 4};
	localparam int RIX [6] = '{3, 1, 1, 5, 5, 3};
	localparam logic signed [C+2:0] SMAX = {{4{1'b0}}, {(C-1){1'b1}}};
	localparam logic signed [C+2:0] SMIN = {{4{1'b1}}, {(C-1){1'b0}}};
	localparam logic [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
	localparam logic [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};

	logic          en;
	logic [NV-1:0] vld_q;
	logic          result_valid_q;

	assign en           = !result_valid_q || result_ready;
	assign item_ready   = en;
	assign result_valid = result_valid_q;

	logic signed [C-1:0] p_in [3];
	logic signed [C-1:0] a_in [3];
	logic signed [C-1:0] b_in [3];
	logic signed [C-1:0] c_in [3];

	assign p_in = '{point_x, point_y, point_z};
	assign a_in = '{vert_a_x, vert_a_y, vert_a_z};
	assign b_in = '{vert_b_x, vert_b_y, vert_b_z};
	assign c_in = '{vert_c_x, vert_c_y, vert_c_z};

	// ---- stage 1: difference vectors
	logic signed [C-1:0] a_s1 [3], b_s1 [3], c_s1 [3];
	logic signed [V-1:0] ab_s1 [3], ac_s1 [3], bc_s1 [3];
	logic signed [V-1:0] ap_s1 [3], bp_s1 [3], cp_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i]  <= a_in[i];
				b_s1[i]  <= b_in[i];
				c_s1[i]  <= c_in[i];
				ab_s1[i] <= V'(b_in[i]) - V'(a_in[i]);
				ac_s1[i] <= V'(c_in[i]) - V'(a_in[i]);
				bc_s1[i] <= V'(c_in[i]) - V'(b_in[i]);
				ap_s1[i] <= V'(p_in[i]) - V'(a_in[i]);
				bp_s1[i] <= V'(p_in[i]) - V'(b_in[i]);
				cp_s1[i] <= V'(p_in[i]) - V'(c_in[i]);
			end
		end
	end

	// ---- stage 2: coordinate products of the six dot products
	logic signed [V-1:0]  dl [6][3];
	logic signed [V-1:0]  dr [6][3];
	logic signed [PW-1:0] m_s2 [6][3];
	logic signed [C-1:0]  a_s2 [3], b_s2 [3], c_s2 [3];
	logic signed [V-1:0]  ab_s2 [3], ac_s2 [3], bc_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dl[0][i] = ab_s1[i]; dr[0][i] = ap_s1[i];
			dl[1][i] = ac_s1[i]; dr[1][i] = ap_s1[i];
			dl[2][i] = ab_s1[i]; dr[2][i] = bp_s1[i];
			dl[3][i] = ac_s1[i]; dr[3][i] = bp_s1[i];
			dl[4][i] = ab_s1[i]; dr[4][i] = cp_s1[i];
			dl[5][i] = ac_s1[i]; dr[5][i] = cp_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				for (int i = 0; i < 3; i++) begin
					m_s2[j][i] <= PW'(dl[j][i]) * PW'(dr[j][i]);
				end
			end
			a_s2  <= a_s1;  b_s2  <= b_s1;  c_s2  <= c_s1;
			ab_s2 <= ab_s1; ac_s2 <= ac_s1; bc_s2 <= bc_s1;
		end
	end

	// ---- stage 3: dot products d1..d6
	logic signed [DOT-1:0] d_s3 [6];
	logic signed [C-1:0]   a_s3 [3], b_s3 [3], c_s3 [3];
	logic signed [V-1:0]   ab_s3 [3], ac_s3 [3], bc_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				d_s3[j] <= DOT'(m_s2[j][0]) + DOT'(m_s2[j][1]) + DOT'(m_s2[j][2]);
			end
			a_s3  <= a_s2;  b_s3  <= b_s2;  c_s3  <= c_s2;
			ab_s3 <= ab_s2; ac_s3 <= ac_s2; bc_s3 <= bc_s2;
		end
	end

	// ---- stage 4: partial products of the barycentric terms
	logic signed [XW-1:0]    dhi [6];
	logic signed [XW-1:0]    dlo [6];
	logic signed [PPW-1:0]   pp_s4 [6][4];
	logic signed [DOT-1:0]   d_s4 [6];
	logic signed [DOT:0]     n43_s4, n56_s4;
	logic signed [C-1:0]     a_s4 [3], b_s4 [3], c_s4 [3];
	logic signed [V-1:0]     ab_s4 [3], ac_s4 [3], bc_s4 [3];

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			dhi[j] = XW'($signed(d_s3[j][DOT-1:H1]));
			dlo[j] = {1'b0, d_s3[j][H1-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				pp_s4[j][0] <= PPW'(dhi[LIX[j]]) * PPW'(dhi[RIX[j]]);
				pp_s4[j][1] <= PPW'(dhi[LIX[j]]) * PPW'(dlo[RIX[j]]);
				pp_s4[j][2] <= PPW'(dlo[LIX[j]]) * PPW'(dhi[RIX[j]]);
				pp_s4[j][3] <= PPW'(dlo[LIX[j]]) * PPW'(dlo[RIX[j]]);
			end
			n43_s4 <= (DOT+1)'(d_s3[3]) - (DOT+1)'(d_s3[2]);
			n56_s4 <= (DOT+1)'(d_s3[4]) - (DOT+1)'(d_s3[5]);
			d_s4  <= d_s3;
			a_s4  <= a_s3;  b_s4  <= b_s3;  c_s4  <= c_s3;
			ab_s4 <= ab_s3; ac_s4 <= ac_s3; bc_s4 <= bc_s3;
		end
	end

	// ---- stage 5: assemble the six products
	logic signed [BW-1:0]  prod_s5 [6];
	logic signed [DOT-1:0] d_s5 [6];
	logic signed [DOT:0]   n43_s5, n56_s5;
	logic signed [C-1:0]   a_s5 [3], b_s5 [3], c_s5 [3];
	logic signed [V-1:0]   ab_s5 [3], ac_s5 [3], bc_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				prod_s5[j] <= (BW'(pp_s4[j][0]) <<< (2 * H1))
					+ ((BW'(pp_s4[j][1]) + BW'(pp_s4[j][2])) <<< H1)
					+ BW'(pp_s4[j][3]);
			end
			n43_s5 <= n43_s4; n56_s5 <= n56_s4; d_s5 <= d_s4;
			a_s5  <= a_s4;  b_s5  <= b_s4;  c_s5  <= c_s4;
			ab_s5 <= ab_s4; ac_s5 <= ac_s4; bc_s5 <= bc_s4;
		end
	end

	// ---- stage 6: vc, vb, va
	logic signed [BAR-1:0] vc_s6, vb_s6, va_s6;
	logic signed [DOT-1:0] d_s6 [6];
	logic signed [DOT:0]   n43_s6, n56_s6;
	logic signed [C-1:0]   a_s6 [3], b_s6 [3], c_s6 [3];
	logic signed [V-1:0]   ab_s6 [3], ac_s6 [3], bc_s6 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			vc_s6 <= BAR'(prod_s5[0]) - BAR'(prod_s5[1]);
			vb_s6 <= BAR'(prod_s5[2]) - BAR'(prod_s5[3]);
			va_s6 <= BAR'(prod_s5[4]) - BAR'(prod_s5[5]);
			n43_s6 <= n43_s5; n56_s6 <= n56_s5; d_s6 <= d_s5;
			a_s6  <= a_s5;  b_s6  <= b_s5;  c_s6  <= c_s5;
			ab_s6 <= ab_s5; ac_s6 <= ac_s5; bc_s6 <= bc_s5;
		end
	end

	// ---- stage 7: interior and edge divisors
	logic signed [DEN-1:0] den_s7;
	logic signed [EW-1:0]  dv2_s7, dv4_s7, dv5_s7;
	logic signed [BAR-1:0] vc_s7, vb_s7, va_s7;
	logic signed [DOT-1:0] d_s7 [6];
	logic signed [DOT:0]   n43_s7, n56_s7;
	logic signed [C-1:0]   a_s7 [3], b_s7 [3], c_s7 [3];
	logic signed [V-1:0]   ab_s7 [3], ac_s7 [3], bc_s7 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			den_s7 <= DEN'(va_s6) + DEN'(vb_s6) + DEN'(vc_s6);
			dv2_s7 <= EW'(d_s6[0]) - EW'(d_s6[2]);
			dv4_s7 <= EW'(d_s6[1]) - EW'(d_s6[5]);
			dv5_s7 <= EW'(n43_s6) + EW'(n56_s6);
			vc_s7 <= vc_s6; vb_s7 <= vb_s6; va_s7 <= va_s6;
			n43_s7 <= n43_s6; n56_s7 <= n56_s6; d_s7 <= d_s6;
			a_s7  <= a_s6;  b_s7  <= b_s6;  c_s7  <= c_s6;
			ab_s7 <= ab_s6; ac_s7 <= ac_s6; bc_s7 <= bc_s6;
		end
	end

	// ---- stage 8: region decision and operand selection
	logic [2:0]            rgn_c;
	logic signed [C-1:0]   base_c [3];
	logic signed [V-1:0]   u_c [3], w_c [3];
	logic signed [BAR-1:0] sf_c, tf_c;
	logic signed [DEN-1:0] den_c;

	always_comb begin
		rgn_c = cpt_pkg::RGN_A;
		base_c = a_s7;
		u_c = '{default: '0};
		w_c = '{default: '0};
		sf_c = '0;
		tf_c = '0;
		den_c = DEN'(1);
		if (d_s7[0] <= 0 && d_s7[1] <= 0) begin
			rgn_c = cpt_pkg::RGN_A;
		end else if (d_s7[2] >= 0 && n43_s7 <= 0) begin
			rgn_c = cpt_pkg::RGN_B;
			base_c = b_s7;
		end else if (vc_s7 <= 0 && d_s7[0] >= 0 && d_s7[2] <= 0) begin
			rgn_c = cpt_pkg::RGN_AB;
			if (dv2_s7 != 0) begin
				u_c = ab_s7;
				sf_c = BAR'(d_s7[0]);
				den_c = DEN'(dv2_s7);
			end
		end else if (d_s7[5] >= 0 && n56_s7 <= 0) begin
			rgn_c = cpt_pkg::RGN_C;
			base_c = c_s7;
		end else if (vb_s7 <= 0 && d_s7[1] >= 0 && d_s7[5] <= 0) begin
			rgn_c = cpt_pkg::RGN_AC;
			if (dv4_s7 != 0) begin
				u_c = ac_s7;
				sf_c = BAR'(d_s7[1]);
				den_c = DEN'(dv4_s7);
			end
		end else if (va_s7 <= 0 && n43_s7 >= 0 && n56_s7 >= 0) begin
			rgn_c = cpt_pkg::RGN_BC;
			base_c = b_s7;
			if (dv5_s7 != 0) begin
				u_c = bc_s7;
				sf_c = BAR'(n43_s7);
				den_c = DEN'(dv5_s7);
			end
		end else if (den_s7 == 0) begin
			rgn_c = cpt_pkg::RGN_DEGEN;
		end else begin
			rgn_c = cpt_pkg::RGN_INNER;
			u_c = ab_s7;
			w_c = ac_s7;
			sf_c = vb_s7;
			tf_c = vc_s7;
			den_c = den_s7;
		end
	end

	logic [2:0]            rgn_s8;
	logic signed [C-1:0]   base_s8 [3];
	logic signed [V-1:0]   u_s8 [3], w_s8 [3];
	logic signed [P:0]     sp_s8 [4], tp_s8 [4];
	logic signed [DEN-1:0] den_s8;

	// split the weights into pieces, the top one signed
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sp_s8[k] <= {1'b0, sf_c[k*P +: P]};
				tp_s8[k] <= {1'b0, tf_c[k*P +: P]};
			end
			sp_s8[3] <= (P+1)'($signed(sf_c[BAR-1:3*P]));
			tp_s8[3] <= (P+1)'($signed(tf_c[BAR-1:3*P]));
			rgn_s8 <= rgn_c; base_s8 <= base_c;
			u_s8 <= u_c; w_s8 <= w_c; den_s8 <= den_c;
		end
	end

	// ---- stage 9: vector times weight pieces
	logic signed [QPW-1:0] pu_s9 [3][4], pw_s9 [3][4];
	logic [2:0]            rgn_s9;
	logic signed [C-1:0]   base_s9 [3];
	logic signed [DEN-1:0] den_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 4; k++) begin
					pu_s9[i][k] <= QPW'(u_s8[i]) * QPW'(sp_s8[k]);
					pw_s9[i][k] <= QPW'(w_s8[i]) * QPW'(tp_s8[k]);
				end
			end
			rgn_s9 <= rgn_s8; base_s9 <= base_s8; den_s9 <= den_s8;
		end
	end

	// ---- stage 10: assemble the two products per coordinate
	logic signed [UW-1:0]  su_c [3], sw_c [3];
	logic signed [UW-1:0]  su_s10 [3], sw_s10 [3];
	logic [2:0]            rgn_s10;
	logic signed [C-1:0]   base_s10 [3];
	logic signed [DEN-1:0] den_s10;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			su_c[i] = '0;
			sw_c[i] = '0;
			for (int k = 0; k < 4; k++) begin
				su_c[i] = su_c[i] + (UW'(pu_s9[i][k]) <<< (k * P));
				sw_c[i] = sw_c[i] + (UW'(pw_s9[i][k]) <<< (k * P));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			su_s10 <= su_c; sw_s10 <= sw_c;
			rgn_s10 <= rgn_s9; base_s10 <= base_s9; den_s10 <= den_s9;
		end
	end

	// ---- stage 11: numerators
	logic signed [NUM-1:0] n_s11 [3];
	logic [2:0]            rgn_s11;
	logic signed [C-1:0]   base_s11 [3];
	logic signed [DEN-1:0] den_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s11[i] <= NUM'(su_s10[i]) + NUM'(sw_s10[i]);
			end
			rgn_s11 <= rgn_s10; base_s11 <= base_s10; den_s11 <= den_s10;
		end
	end

	// ---- stage 12: magnitudes and quotient sign
	logic [NUM-1:0]      nabs_s12 [3];
	logic [DEN-1:0]      dabs_s12;
	logic [2:0]          neg_s12;
	logic [2:0]          rgn_s12;
	logic signed [C-1:0] base_s12 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nabs_s12[i] <= n_s11[i][NUM-1] ? NUM'(-n_s11[i]) : NUM'(n_s11[i]);
				neg_s12[i]  <= n_s11[i][NUM-1] ^ den_s11[DEN-1];
			end
			dabs_s12 <= den_s11[DEN-1] ? DEN'(-den_s11) : DEN'(den_s11);
			rgn_s12 <= rgn_s11; base_s12 <= base_s11;
		end
	end

	// ---- stage 13: add half the divisor for round-half-away
	logic [NMW-1:0]      nh_s13 [3];
	logic [DEN-1:0]      dabs_s13;
	logic [2:0]          neg_s13;
	logic [2:0]          rgn_s13;
	logic signed [C-1:0] base_s13 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nh_s13[i] <= NMW'(nabs_s12[i]) + NMW'(dabs_s12 >> 1);
			end
			dabs_s13 <= dabs_s12; neg_s13 <= neg_s12;
			rgn_s13 <= rgn_s12; base_s13 <= base_s12;
		end
	end

	// ---- stage 14: quotient range check
	logic [NMW-1:0]      nh_s14 [3];
	logic [DEN-1:0]      dabs_s14;
	logic [2:0]          neg_s14;
	logic [2:0]          ovf_s14;
	logic [2:0]          rgn_s14;
	logic signed [C-1:0] base_s14 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ovf_s14[i] <= RW'(nh_s13[i]) >= (RW'(dabs_s13) << QW);
			end
			nh_s14 <= nh_s13; dabs_s14 <= dabs_s13; neg_s14 <= neg_s13;
			rgn_s14 <= rgn_s13; base_s14 <= base_s13;
		end
	end

	// ---- divider stages
	cpt_pkg::div_flags_t flg_in [3];
	logic [QW-1:0]       quo_d [3];
	cpt_pkg::div_flags_t flg_d [3];
	logic [C-1:0]        base_d [3];
	logic [2:0]          rgn_q [QW];

	for (genvar gi = 0; gi < 3; gi++) begin : g_div
		assign flg_in[gi] = '{neg: neg_s14[gi], ovf: ovf_s14[gi]};

		cpt_div #(
			.NW (NMW),
			.DW (DEN),
			.QW (QW),
			.TW (C)
		) u_div (
			.clk   (clk),
			.en    (en),
			.num   (nh_s14[gi]),
			.den   (dabs_s14),
			.flg   (flg_in[gi]),
			.tag   (base_s14[gi]),
			.quo   (quo_d[gi]),
			.flg_o (flg_d[gi]),
			.tag_o (base_d[gi])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgn_q[0] <= rgn_s14;
			for (int k = 1; k < QW; k++) begin
				rgn_q[k] <= rgn_q[k-1];
			end
		end
	end

	// ---- final add and saturation
	logic signed [C+2:0] qs_c [3];
	logic signed [C+2:0] sum_c [3];
	logic [C-1:0]        res_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qs_c[i]  = flg_d[i].neg ? -(C+3)'(quo_d[i]) : (C+3)'(quo_d[i]);
			sum_c[i] = (C+3)'($signed(base_d[i])) + qs_c[i];
			if (flg_d[i].ovf) begin
				res_c[i] = flg_d[i].neg ? CMIN : CMAX;
			end else if (sum_c[i] > SMAX) begin
				res_c[i] = CMAX;
			end else if (sum_c[i] < SMIN) begin
				res_c[i] = CMIN;
			end else begin
				res_c[i] = sum_c[i][C-1:0];
			end
		end
	end

	// ---- valid tracking and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q          <= '0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			vld_q          <= {vld_q[NV-2:0], item_valid};
			result_valid_q <= vld_q[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_q[NV-1]) begin
			near_x <= res_c[0];
			near_y <= res_c[1];
			near_z <= res_c[2];
			region <= rgn_q[QW-1];
		end
	end

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> $stable(vld_q))
		else $error("pipeline moved during output stall");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && !result_ready))
		else $error("input refused without an output stall");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(vld_q[NV-1]))
		else $error("result appeared without a transaction in the last stage");
`endif

endmodule

### dv/cpt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpt_checker
// Watches both channels of closest_point_on_triangle, predicts the nearest
// point and region of every accepted query and compares each result with
// the oldest pending prediction.
// ----------------------------------------------------------------------------
module cpt_checker
	import cpt_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	input  logic signed [COORD_BITS-1:0] vert_a_x,
	input  logic signed [COORD_BITS-1:0] vert_a_y,
	input  logic signed [COORD_BITS-1:0] vert_a_z,
	input  logic signed [COORD_BITS-1:0] vert_b_x,
	input  logic signed [COORD_BITS-1:0] vert_b_y,
	input  logic signed [COORD_BITS-1:0] vert_b_z,
	input  logic signed [COORD_BITS-1:0] vert_c_x,
	input  logic signed [COORD_BITS-1:0] vert_c_y,
	input  logic signed [COORD_BITS-1:0] vert_c_z,
	input  logic                         result_valid,
	input  logic                         result_ready,
	input  logic signed [COORD_BITS-1:0] near_x,
	input  logic signed [COORD_BITS-1:0] near_y,
	input  logic signed [COORD_BITS-1:0] near_z,
	input  logic [2:0]                   region,
	output int                           errors,
	output int                           pending
);

	typedef logic signed [255:0] wide_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef struct {
		coord_t     pos[3];
		logic [2:0] rgn;
	} nearest_t;

	nearest_t nearest_q[$];

	function automatic wide_t div_round(wide_t n, wide_t d);
		logic neg;
		wide_t q;
		if (d < 0) begin
			d = -d;
			n = -n;
		end
		neg = n < 0;
		if (neg) n = -n;
		q = (n + (d >>> 1)) / d;
		return neg ? -q : q;
	endfunction

	function automatic coord_t clamp(wide_t v);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (COORD_BITS - 1)) - 1;
		lo = -(wide_t'(1) <<< (COORD_BITS - 1));
		if (v > hi) return coord_t'(hi);
		if (v < lo) return coord_t'(lo);
		return coord_t'(v);
	endfunction

	function automatic wide_t dot3(wide_t u[3], wide_t v[3]);
		return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
	endfunction

	function automatic nearest_t nearest_point(coord_t f[12]);
		wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
		wide_t base[3], dir[3];
		wide_t d1, d2, d3, d4, d5, d6, vc, vb, va, n43, n56, num, dv;
		int mode;
		nearest_t r;
		for (int i = 0; i < 3; i++) begin
			p[i] = f[i];
			a[i] = f[3 + i];
			b[i] = f[6 + i];
			c[i] = f[9 + i];
			ab[i] = b[i] - a[i];
			ac[i] = c[i] - a[i];
			ap[i] = p[i] - a[i];
			bp[i] = p[i] - b[i];
			cp[i] = p[i] - c[i];
			bc[i] = c[i] - b[i];
		end
		d1 = dot3(ab, ap);
		d2 = dot3(ac, ap);
		d3 = dot3(ab, bp);
		d4 = dot3(ac, bp);
		d5 = dot3(ab, cp);
		d6 = dot3(ac, cp);
		vc = d1 * d4 - d3 * d2;
		vb = d5 * d2 - d1 * d6;
		va = d3 * d6 - d5 * d4;
		n43 = d4 - d3;
		n56 = d5 - d6;
		mode = 0;
		num = 0;
		dv = 0;
		base = a;
		dir = ab;
		if (d1 <= 0 && d2 <= 0) begin
			r.rgn = RGN_A;
		end else if (d3 >= 0 && n43 <= 0) begin
			r.rgn = RGN_B;
			base = b;
		end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
			r.rgn = RGN_AB;
			num = d1;
			dv = d1 - d3;
			mode = 1;
		end else if (d6 >= 0 && n56 <= 0) begin
			r.rgn = RGN_C;
			base = c;
		end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
			r.rgn = RGN_AC;
			dir = ac;
			num = d2;
			dv = d2 - d6;
			mode = 1;
		end else if (va <= 0 && n43 >= 0 && n56 >= 0) begin
			r.rgn = RGN_BC;
			base = b;
			dir = bc;
			num = n43;
			dv = n43 + n56;
			mode = 1;
		end else begin
			dv = va + vb + vc;
			if (dv == 0) begin
				r.rgn = RGN_DEGEN;
			end else begin
				r.rgn = RGN_INNER;
				mode = 2;
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (mode == 1 && dv != 0)
				r.pos[i] = clamp(base[i] + div_round(dir[i] * num, dv));
			else if (mode == 2)
				r.pos[i] = clamp(a[i] + div_round(ab[i] * vb + ac[i] * vc, dv));
			else
				r.pos[i] = clamp(base[i]);
		end
		return r;
	endfunction

	assign pending = nearest_q.size();

	always @(posedge clk or negedge arst_n) begin
		coord_t   f[12];
		nearest_t e;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (item_valid && item_ready) begin
				f = '{point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
				      vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z};
				nearest_q.push_back(nearest_point(f));
			end
			if (result_valid && result_ready) begin
				if (nearest_q.size() == 0) begin
					$error("result transaction with nothing pending");
					errors <= errors + 1;
				end else begin
					e = nearest_q.pop_front();
					if (near_x !== e.pos[0] || near_y !== e.pos[1] || near_z !== e.pos[2]
					    || region !== e.rgn) begin
						if (near_x !== e.pos[0])
							$error("near_x: expected %0d, got %0d", e.pos[0], near_x);
						if (near_y !== e.pos[1])
							$error("near_y: expected %0d, got %0d", e.pos[1], near_y);
						if (near_z !== e.pos[2])
							$error("near_z: expected %0d, got %0d", e.pos[2], near_z);
						if (region !== e.rgn)
							$error("region: expected %0d, got %0d", e.rgn, region);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives closest_point_on_triangle with directed and random triangle queries
// under random idling and a long output stall; the checker judges results.
// ----------------------------------------------------------------------------
module tb_top;
	import cpt_pkg::*;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam int ONE = 1 << 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;

	logic   clk, arst_n;
	logic   item_valid, item_ready, result_valid, result_ready;
	coord_t fld[12];
	coord_t near_x, near_y, near_z;
	logic [2:0] region;
	int     errors, pending;
	int     sender_idle, receiver_idle, hold_cycles, quiet;

	closest_point_on_triangle dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.point_x(fld[0]), .point_y(fld[1]), .point_z(fld[2]),
		.vert_a_x(fld[3]), .vert_a_y(fld[4]), .vert_a_z(fld[5]),
		.vert_b_x(fld[6]), .vert_b_y(fld[7]), .vert_b_z(fld[8]),
		.vert_c_x(fld[9]), .vert_c_y(fld[10]), .vert_c_z(fld[11]),
		.result_valid(result_valid), .result_ready(result_ready),
		.near_x(near_x), .near_y(near_y), .near_z(near_z), .region(region)
	);

	cpt_checker chk (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.point_x(fld[0]), .point_y(fld[1]), .point_z(fld[2]),
		.vert_a_x(fld[3]), .vert_a_y(fld[4]), .vert_a_z(fld[5]),
		.vert_b_x(fld[6]), .vert_b_y(fld[7]), .vert_b_z(fld[8]),
		.vert_c_x(fld[9]), .vert_c_y(fld[10]), .vert_c_z(fld[11]),
		.result_valid(result_valid), .result_ready(result_ready),
		.near_x(near_x), .near_y(near_y), .near_z(near_z), .region(region),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			result_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			result_ready <= ($urandom_range(99) >= receiver_idle);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send(input coord_t q[12]);
		if ($urandom_range(99) < sender_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle) @(posedge clk);
		end
		item_valid <= 1'b1;
		for (int i = 0; i < 12; i++) fld[i] <= q[i];
		do @(posedge clk); while (!item_ready);
	endtask

	// triangle: point, then vertices a, b, c
	task automatic send_tri(input coord_t p[3], input coord_t a[3],
	                        input coord_t b[3], input coord_t c[3]);
		send('{p[0], p[1], p[2], a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]});
	endtask

	function automatic coord_t near_offset(coord_t center, int span);
		return center + coord_t'($signed($urandom_range(2 * span)) - span);
	endfunction

	task automatic send_random();
		coord_t q[12];
		coord_t ctr[3];
		int     span, kind;
		kind = $urandom_range(99);
		span = 1 << $urandom_range(4, 24);
		for (int i = 0; i < 3; i++) ctr[i] = coord_t'($urandom_range(1 << 30)) - (1 << 29);
		if (kind < 25) begin
			for (int i = 0; i < 12; i++) q[i] = coord_t'($urandom);
		end else begin
			for (int i = 0; i < 12; i++) q[i] = near_offset(ctr[i % 3], span);
			if (kind >= 80) begin
				// collapse vertices or make them collinear
				case ($urandom_range(3))
					0: for (int i = 0; i < 3; i++) q[6 + i] = q[3 + i];
					1: for (int i = 0; i < 3; i++) q[9 + i] = q[6 + i];
					2: for (int i = 0; i < 3; i++) q[9 + i] = q[3 + i];
					default: for (int i = 0; i < 3; i++) begin
						q[6 + i] = q[3 + i] + (q[9 + i] - q[3 + i]) / 2;
					end
				endcase
			end
		end
		send(q);
	endtask

	initial begin
		coord_t o[3], ex[3], ey[3], mx[3], mn[3];
		item_valid = 1'b0;
		result_ready = 1'b0;
		hold_cycles = 0;
		quiet = 0;
		sender_idle = 16;
		receiver_idle = 60;
		for (int i = 0; i < 12; i++) fld[i] = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		o = '{0, 0, 0};
		ex = '{ONE, 0, 0};
		ey = '{0, ONE, 0};
		mx = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
		mn = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
		// every region of the unit right triangle
		send_tri('{-ONE, -ONE, 5}, o, ex, ey);
		send_tri('{2 * ONE, -ONE, 0}, o, ex, ey);
		send_tri('{ONE / 3, -ONE, ONE}, o, ex, ey);
		send_tri('{-ONE, 2 * ONE, 0}, o, ex, ey);
		send_tri('{-ONE, ONE / 3, -ONE}, o, ex, ey);
		send_tri('{ONE, ONE, 7}, o, ex, ey);
		send_tri('{ONE / 4, ONE / 5, ONE}, o, ex, ey);
		send_tri('{ONE / 3 + 1, ONE / 7 + 3, -ONE}, o, ex, ey);
		// degenerate: a point, and a collinear triangle
		send_tri('{ONE, ONE, ONE}, ex, ex, ex);
		send_tri('{ONE / 2, ONE, 0}, o, ex, '{2 * ONE, 0, 0});
		// zero-length edges
		send_tri('{ONE, ONE, 0}, o, o, ey);
		send_tri('{ONE, ONE, 0}, o, ex, o);
		send_tri('{ONE, -ONE, 0}, o, ex, ex);
		// coordinate extremes
		send_tri(mx, mn, mx, mn);
		send_tri(mn, mx, mn, mx);
		send_tri(mx, mn, '{32'sh80000000, 32'sh7fffffff, 0}, '{0, 32'sh80000000, 32'sh7fffffff});
		send_tri(o, mn, mx, '{32'sh7fffffff, 32'sh80000000, 0});
		send_tri(mn, o, mx, '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff});
		send_tri('{-1, -1, -1}, '{1, 1, 1}, '{-1, 1, -1}, '{1, -1, 1});

		for (int k = 0; k < 330; k++) send_random();
		sender_idle = 60;
		receiver_idle = 16;
		for (int k = 0; k < 330; k++) send_random();
		sender_idle = 0;
		receiver_idle = 0;
		hold_cycles = 300;
		for (int k = 0; k < 340; k++) send_random();
		item_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
